// File: rtl/core/mlrq_pkg.sv
// ----------------------------------------------------------------------------
// Multilevel ready queue scheduler package
// Shared widths, default sizes, request and status codes, and controller states.
// ----------------------------------------------------------------------------
package mlrq_pkg;

   localparam int NUM_LEVELS_DEF = 8;
   localparam int RING_DEPTH_DEF = 16;
   localparam int MAX_TASKS_DEF  = 64;

   localparam int CMD_W    = 2;
   localparam int TASK_W   = 6;
   localparam int PRIO_W   = 4;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD       = 2'd0,
      CMD_REMOVE    = 2'd1,
      CMD_SCHEDULE  = 2'd2,
      CMD_SET_READY = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK               = 2'd0,
      ST_BAD_LEVEL        = 2'd1,
      ST_FULL_OR_MISMATCH = 2'd2,
      ST_NONE_READY       = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_FETCH  = 2'd1,
      S_DECIDE = 2'd2,
      S_DONE   = 2'd3
   } state_type;

endpackage

// File: rtl/core/mlrq_ifs.sv
// ----------------------------------------------------------------------------
// Multilevel ready queue scheduler channels
// Valid/ready interfaces for the request and response channels.
// ----------------------------------------------------------------------------
interface mlrq_req_if
   import mlrq_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [TASK_W-1:0] task_id;
   logic [PRIO_W-1:0] priority_req;
   logic              ready_flag;

   modport source (output valid, cmd, task_id, priority_req, ready_flag, input ready);
   modport sink (input valid, cmd, task_id, priority_req, ready_flag, output ready);
endinterface

interface mlrq_rsp_if
   import mlrq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TASK_W-1:0]   task_id_out;

   modport source (output valid, status, task_id_out, input ready);
   modport sink (input valid, status, task_id_out, output ready);
endinterface

// File: rtl/core/multilevel_ready_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// Multilevel ready queue scheduler
// Add, remove and set ready pass through the fetch, decide and done states from
// request acceptance to a valid response. Schedule returns to fetch for each
// non-ready entry moved to its tail and for each level moved past, since each
// decision waits on a registered slot memory read. One request is in flight at a
// time, so a new request is taken only back in idle; a response may wait while the next is taken.
// Synchronous reset empties every ring and marks every task not ready.
// ----------------------------------------------------------------------------
module multilevel_ready_queue_scheduler_top
   import mlrq_pkg::*;
#(
   parameter int NUM_LEVELS = NUM_LEVELS_DEF,
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   parameter int MAX_TASKS  = MAX_TASKS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mlrq_req_if.sink   req_chan,
   mlrq_rsp_if.source rsp_chan
);

   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int POS_W  = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int TIX_W  = $clog2(MAX_TASKS);
   localparam int ADDR_W = $clog2(NUM_LEVELS * RING_DEPTH);
   localparam int DEPTH  = NUM_LEVELS * RING_DEPTH;

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
      return (p == POS_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] l,
                                                   input logic [POS_W-1:0] p);
      return ADDR_W'(int'(l) * RING_DEPTH + int'(p));
   endfunction

   state_type state_ff, state_in;

   cmd_type           cmd_ff, cmd_in;
   logic [TASK_W-1:0] tid_ff, tid_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic              lvl_bad_ff, lvl_bad_in;
   logic              flag_ff, flag_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   status_type        res_status_ff, res_status_in;
   logic [TASK_W-1:0] res_tid_ff, res_tid_in;

   logic [POS_W-1:0] head_ff  [NUM_LEVELS];
   logic [POS_W-1:0] tail_ff  [NUM_LEVELS];
   logic [CNT_W-1:0] count_ff [NUM_LEVELS];
   logic             ring_we;
   logic [POS_W-1:0] head_in, tail_in;
   logic [CNT_W-1:0] count_in;

   logic [MAX_TASKS-1:0] ready_ff;
   logic                 ready_we;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [TASK_W-1:0] rsp_tid_ff;

   logic [TASK_W-1:0] mem [DEPTH];
   logic [TASK_W-1:0] rd_data_ff;
   logic              mem_re, mem_we;
   logic [ADDR_W-1:0] mem_raddr, mem_waddr;
   logic [TASK_W-1:0] mem_wdata;

   logic             req_fire, rsp_free;
   logic [POS_W-1:0] cur_head, cur_tail;
   logic [CNT_W-1:0] cur_count;
   logic             sched_empty, sched_last, cand_ready;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign cur_head  = head_ff[lvl_ff];
   assign cur_tail  = tail_ff[lvl_ff];
   assign cur_count = count_ff[lvl_ff];

   assign sched_empty = (remain_ff == '0);
   assign sched_last  = (lvl_ff == LVL_W'(NUM_LEVELS - 1));
   assign cand_ready  = ({1'b0, rd_data_ff} < (TASK_W + 1)'(MAX_TASKS)) &&
                        ready_ff[rd_data_ff[TIX_W-1:0]];

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.task_id_out = rsp_tid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (cmd_ff == CMD_SCHEDULE && !(sched_empty && sched_last) &&
                !(!sched_empty && cand_ready)) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      tid_in        = tid_ff;
      lvl_in        = lvl_ff;
      lvl_bad_in    = lvl_bad_ff;
      flag_in       = flag_ff;
      remain_in     = remain_ff;
      res_status_in = res_status_ff;
      res_tid_in    = res_tid_ff;
      ring_we       = 1'b0;
      head_in       = cur_head;
      tail_in       = cur_tail;
      count_in      = cur_count;
      ready_we      = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = slot_addr(lvl_ff, cur_head);
      mem_we        = 1'b0;
      mem_waddr     = slot_addr(lvl_ff, cur_tail);
      mem_wdata     = tid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in  = cmd_type'(req_chan.cmd);
               tid_in  = req_chan.task_id;
               flag_in = req_chan.ready_flag;
               if (cmd_type'(req_chan.cmd) == CMD_SCHEDULE) begin
                  lvl_in     = '0;
                  lvl_bad_in = 1'b0;
                  remain_in  = count_ff[0];
               end else begin
                  lvl_in     = req_chan.priority_req[LVL_W-1:0];
                  lvl_bad_in = ({1'b0, req_chan.priority_req} >=
                                (PRIO_W + 1)'(NUM_LEVELS));
               end
            end
         end
         S_FETCH: begin
            mem_re = !lvl_bad_ff;
         end
         S_DECIDE: begin
            res_status_in = ST_OK;
            res_tid_in    = tid_ff;
            unique case (cmd_ff)
               CMD_ADD: begin
                  if (lvl_bad_ff) begin
                     res_status_in = ST_BAD_LEVEL;
                     res_tid_in    = '0;
                  end else if (cur_count >= CNT_W'(RING_DEPTH)) begin
                     res_status_in = ST_FULL_OR_MISMATCH;
                     res_tid_in    = '0;
                  end else begin
                     mem_we   = 1'b1;
                     ring_we  = 1'b1;
                     tail_in  = next_pos(cur_tail);
                     count_in = cur_count + 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  if (lvl_bad_ff) begin
                     res_status_in = ST_BAD_LEVEL;
                     res_tid_in    = '0;
                  end else if (cur_count == '0 || rd_data_ff != tid_ff) begin
                     res_status_in = ST_FULL_OR_MISMATCH;
                     res_tid_in    = '0;
                  end else begin
                     ring_we  = 1'b1;
                     head_in  = next_pos(cur_head);
                     count_in = cur_count - 1'b1;
                  end
               end
               CMD_SET_READY: begin
                  ready_we = ({1'b0, tid_ff} < (TASK_W + 1)'(MAX_TASKS));
               end
               CMD_SCHEDULE: begin
                  if (sched_empty) begin
                     if (sched_last) begin
                        res_status_in = ST_NONE_READY;
                        res_tid_in    = '0;
                     end else begin
                        lvl_in    = lvl_ff + 1'b1;
                        remain_in = count_ff[LVL_W'(lvl_ff + 1'b1)];
                     end
                  end else if (cand_ready) begin
                     res_tid_in = rd_data_ff;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = rd_data_ff;
                     ring_we   = 1'b1;
                     head_in   = next_pos(cur_head);
                     tail_in   = next_pos(cur_tail);
                     remain_in = remain_ff - 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ready_ff     <= '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ring_we) begin
            head_ff[lvl_ff]  <= head_in;
            tail_ff[lvl_ff]  <= tail_in;
            count_ff[lvl_ff] <= count_in;
         end
         if (ready_we) begin
            ready_ff[tid_ff[TIX_W-1:0]] <= flag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      tid_ff        <= tid_in;
      lvl_ff        <= lvl_in;
      lvl_bad_ff    <= lvl_bad_in;
      flag_ff       <= flag_in;
      remain_ff     <= remain_in;
      res_status_ff <= res_status_in;
      res_tid_ff    <= res_tid_in;
      if (state_ff == S_DONE && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_tid_ff    <= res_tid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

endmodule

// File: rtl/core/mlrq_checker.sv
// ----------------------------------------------------------------------------
// Multilevel ready queue scheduler checker
// Port-level assertions on the request and response channels, bound to the top.
// ----------------------------------------------------------------------------
module mlrq_prop_checker
   import mlrq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [TASK_W-1:0]   rsp_task_id_out
);

   // A failed request never reports a task.
   a_fail_no_task: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_task_id_out == '0)
      else $error("nonzero status with nonzero task id");

   // Only one request is in flight, so an accepted request blocks the next.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // Reset leaves no response pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_task_id_out))
      else $error("stalled response changed");

endmodule

bind multilevel_ready_queue_scheduler_top mlrq_prop_checker u_mlrq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_task_id_out (rsp_chan.task_id_out)
);
